### design/psms_pkg.sv
// shared constants for the piet stack machine step block
package psms_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_UNDER = 3'd1;
	localparam logic [2:0] ST_OVER  = 3'd2;
	localparam logic [2:0] ST_DIVZ  = 3'd3;
	localparam logic [2:0] ST_NOP   = 3'd4;

endpackage

### design/psms_ram.sv
// generic single write, single read ram with registered read data
module psms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/piet_stack_machine_step_top.sv
// top level of the piet stack machine step block
//
// usage:
// - input channel s_*: one request per colour transition, fields packed in
//   s_tdata; the block decodes it into a piet command and runs it on the
//   stack held in a single ram
// - output channel m_*: exactly one result per request; m_tuser marks an
//   output character, m_tdata carries the value, status, pointer, chooser
//   and stack depth after the step
// - one request is worked on at a time; s_tready is high only while the
//   block is idle and its output register is empty
// - no operation, underflow and push style commands go from the check
//   state straight to the result; one operand commands first read the
//   top, two operand commands top and second, by registered ram reads
// - divide and modulo by a nonzero divisor then run the bit serial divider and a final state
// - roll runs the divider for count mod depth, then rotates in place
//   by three reversals, each pair swapped by two ram reads and two writes
// - reset clears depth, pointer and chooser; stack contents are left as
//   they are and never read before being written
// - a stalled receiver holds the result in m_tdata; no new request is
//   taken until the result has been taken
module piet_stack_machine_step_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// hue_delta[2:0], light_delta[4:3], codel_size[24:5], input_value[56:25]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_valid[0], out_value[32:1], status[35:33], direction[37:36],
	// chooser[38], depth_now[47:39]
	output logic [47:0] m_tdata,
	// out_is_char[0]
	output logic        m_tuser
);

	localparam int AW = psms_pkg::ADDR_W;
	localparam int CW = psms_pkg::CNT_W;

	typedef enum logic [4:0] {
		C_NOP, C_ADD, C_DIV, C_GT, C_DUP, C_INC,
		C_PUSH, C_SUB, C_MOD, C_PTR, C_ROLL, C_OUTN,
		C_POP, C_MUL, C_NOT, C_SWITCH, C_INN, C_OUTC
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_RD1, S_RD2, S_EXEC, S_DIV, S_DIVF,
		S_RPH, S_SWC, S_SWR1, S_SWR2, S_SWW1, S_SWW2, S_FIN
	} state_t;

	state_t        state_q;
	cmd_t          cmd_q, cmd_d;
	logic [19:0]   codel_q;
	logic [31:0]   inval_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    dir_q;
	logic          cho_q;
	logic [31:0]   a_q, b_q, x_q;
	logic [2:0]    st_q;
	logic          ov_q, oc_q, mv_q;
	logic [31:0]   oval_q;

	// divider registers
	logic [31:0]   rem_q, quo_q, dvs_q;
	logic          qneg_q, rneg_q;
	logic [4:0]    dcnt_q;

	// roll registers
	logic [CW-1:0] n_q, k_q, base_q, lo_q, hi_q;
	logic [1:0]    ph_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	logic          need1, need2, push_cmd, full, accept;
	logic [AW-1:0] top_a, sec_a;
	logic [31:0]   alu, rem_w, quo_w, qres, rres, kw, dvd_in, dvs_in;
	logic [32:0]   rem_sh;
	logic          roll_bad;

	psms_ram #(.WIDTH(32), .DEPTH(psms_pkg::STACK_DEPTH)) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign s_tready = (state_q == S_IDLE) && !mv_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = mv_q;
	assign m_tuser  = oc_q;
	assign m_tdata  = {cnt_q, cho_q, dir_q, st_q, oval_q, ov_q};

	// colour transition decode
	always_comb begin
		cmd_d = C_NOP;
		case (s_tdata[4:3])
			2'd0: begin
				case (s_tdata[2:0])
					3'd1:    cmd_d = C_ADD;
					3'd2:    cmd_d = C_DIV;
					3'd3:    cmd_d = C_GT;
					3'd4:    cmd_d = C_DUP;
					3'd5:    cmd_d = C_INC;
					default: cmd_d = C_NOP;
				endcase
			end
			2'd1: begin
				case (s_tdata[2:0])
					3'd0:    cmd_d = C_PUSH;
					3'd1:    cmd_d = C_SUB;
					3'd2:    cmd_d = C_MOD;
					3'd3:    cmd_d = C_PTR;
					3'd4:    cmd_d = C_ROLL;
					3'd5:    cmd_d = C_OUTN;
					default: cmd_d = C_NOP;
				endcase
			end
			2'd2: begin
				case (s_tdata[2:0])
					3'd0:    cmd_d = C_POP;
					3'd1:    cmd_d = C_MUL;
					3'd2:    cmd_d = C_NOT;
					3'd3:    cmd_d = C_SWITCH;
					3'd4:    cmd_d = C_INN;
					3'd5:    cmd_d = C_OUTC;
					default: cmd_d = C_NOP;
				endcase
			end
			default: cmd_d = C_NOP;
		endcase
	end

	// operand needs of the latched command
	assign need2 = (cmd_q == C_ADD) || (cmd_q == C_SUB) || (cmd_q == C_MUL) ||
		(cmd_q == C_DIV) || (cmd_q == C_MOD) || (cmd_q == C_GT) || (cmd_q == C_ROLL);
	assign need1 = (cmd_q == C_POP) || (cmd_q == C_NOT) || (cmd_q == C_PTR) ||
		(cmd_q == C_SWITCH) || (cmd_q == C_DUP) || (cmd_q == C_OUTN) ||
		(cmd_q == C_OUTC);
	assign push_cmd = (cmd_q == C_PUSH) || (cmd_q == C_INC) || (cmd_q == C_INN);
	assign full     = (cnt_q == CW'(psms_pkg::STACK_DEPTH));
	assign top_a    = AW'(cnt_q - CW'(1));
	assign sec_a    = AW'(cnt_q - CW'(2));
	// roll depth must be non-negative and fit below the two operands
	assign roll_bad = a_q[31] || (a_q > 32'(cnt_q - CW'(2)));

	// second OP top
	always_comb begin
		case (cmd_q)
			C_ADD:   alu = a_q + b_q;
			C_SUB:   alu = a_q - b_q;
			C_MUL:   alu = a_q * b_q;
			C_GT:    alu = ($signed(a_q) > $signed(b_q)) ? 32'd1 : 32'd0;
			default: alu = 32'd0;
		endcase
	end

	// restoring divider step on magnitudes
	assign rem_sh = {rem_q, quo_q[31]};
	always_comb begin
		if (rem_sh >= {1'b0, dvs_q}) begin
			rem_w = 32'(rem_sh - {1'b0, dvs_q});
			quo_w = {quo_q[30:0], 1'b1};
		end else begin
			rem_w = rem_sh[31:0];
			quo_w = {quo_q[30:0], 1'b0};
		end
	end
	assign qres   = qneg_q ? -quo_q : quo_q;
	assign rres   = rneg_q ? -rem_q : rem_q;
	assign kw     = rres[31] ? (rres + 32'(n_q)) : rres;
	assign dvd_in = (cmd_q == C_ROLL) ? b_q : a_q;
	assign dvs_in = (cmd_q == C_ROLL) ? 32'(CW'(a_q)) : b_q;

	// stack ram access
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		case (state_q)
			S_CHECK: begin
				raddr = top_a;
				if (push_cmd && !full) begin
					we    = 1'b1;
					waddr = AW'(cnt_q);
					wdata = (cmd_q == C_PUSH) ? 32'(codel_q) : inval_q;
				end
			end
			S_RD1: raddr = sec_a;
			S_EXEC: begin
				case (cmd_q)
					C_DUP: begin
						we    = !full;
						waddr = AW'(cnt_q);
						wdata = b_q;
					end
					C_NOT: begin
						we    = 1'b1;
						waddr = top_a;
						wdata = (b_q == 32'd0) ? 32'd1 : 32'd0;
					end
					C_ADD, C_SUB, C_MUL, C_GT: begin
						we    = 1'b1;
						waddr = sec_a;
						wdata = alu;
					end
					default: we = 1'b0;
				endcase
			end
			S_DIVF: begin
				we    = (cmd_q != C_ROLL);
				waddr = sec_a;
				wdata = (cmd_q == C_DIV) ? qres : rres;
			end
			S_SWR1: raddr = AW'(lo_q);
			S_SWR2: raddr = AW'(hi_q);
			S_SWW1: begin
				we    = 1'b1;
				waddr = AW'(lo_q);
				wdata = rdata;
			end
			S_SWW2: begin
				we    = 1'b1;
				waddr = AW'(hi_q);
				wdata = x_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= C_NOP;
			cnt_q   <= '0;
			dir_q   <= 2'd0;
			cho_q   <= 1'b0;
			mv_q    <= 1'b0;
			st_q    <= psms_pkg::ST_OK;
			ov_q    <= 1'b0;
			oc_q    <= 1'b0;
			oval_q  <= '0;
			ph_q    <= 2'd0;
			dcnt_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (mv_q && m_tready) begin
						mv_q <= 1'b0;
					end
					if (accept) begin
						cmd_q   <= cmd_d;
						codel_q <= s_tdata[24:5];
						inval_q <= s_tdata[56:25];
						st_q    <= psms_pkg::ST_OK;
						ov_q    <= 1'b0;
						oc_q    <= 1'b0;
						oval_q  <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (cmd_q == C_NOP) begin
						st_q    <= psms_pkg::ST_NOP;
						state_q <= S_FIN;
					end else if ((need2 && cnt_q < CW'(2)) ||
						(need1 && cnt_q == '0)) begin
						st_q    <= psms_pkg::ST_UNDER;
						state_q <= S_FIN;
					end else if (push_cmd) begin
						if (full) begin
							st_q <= psms_pkg::ST_OVER;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= S_FIN;
					end else begin
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					b_q     <= rdata;
					state_q <= need2 ? S_RD2 : S_EXEC;
				end
				S_RD2: begin
					a_q     <= rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_FIN;
					case (cmd_q)
						C_DUP: begin
							if (full) begin
								st_q <= psms_pkg::ST_OVER;
							end else begin
								cnt_q <= cnt_q + CW'(1);
							end
						end
						C_POP: cnt_q <= cnt_q - CW'(1);
						C_PTR: begin
							cnt_q <= cnt_q - CW'(1);
							dir_q <= dir_q + b_q[1:0];
						end
						C_SWITCH: begin
							cnt_q <= cnt_q - CW'(1);
							cho_q <= cho_q ^ b_q[0];
						end
						C_OUTN, C_OUTC: begin
							cnt_q  <= cnt_q - CW'(1);
							ov_q   <= 1'b1;
							oc_q   <= (cmd_q == C_OUTC);
							oval_q <= b_q;
						end
						C_ADD, C_SUB, C_MUL, C_GT: cnt_q <= cnt_q - CW'(1);
						C_DIV, C_MOD, C_ROLL: begin
							if ((cmd_q != C_ROLL) && b_q == 32'd0) begin
								st_q <= psms_pkg::ST_DIVZ;
							end else if ((cmd_q == C_ROLL) && roll_bad) begin
								st_q <= psms_pkg::ST_UNDER;
							end else if ((cmd_q == C_ROLL) && a_q == 32'd0) begin
								cnt_q <= cnt_q - CW'(2);
							end else begin
								// load the divider with magnitudes and signs
								if (cmd_q == C_ROLL) begin
									cnt_q <= cnt_q - CW'(2);
									n_q   <= CW'(a_q);
								end
								rem_q   <= '0;
								quo_q   <= dvd_in[31] ? -dvd_in : dvd_in;
								dvs_q   <= dvs_in[31] ? -dvs_in : dvs_in;
								qneg_q  <= dvd_in[31] ^ dvs_in[31];
								rneg_q  <= dvd_in[31];
								dcnt_q  <= '0;
								state_q <= S_DIV;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_DIV: begin
					rem_q  <= rem_w;
					quo_q  <= quo_w;
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) begin
						state_q <= S_DIVF;
					end
				end
				S_DIVF: begin
					if (cmd_q == C_ROLL) begin
						k_q     <= CW'(kw);
						base_q  <= cnt_q - n_q;
						ph_q    <= 2'd0;
						state_q <= (kw == 32'd0) ? S_FIN : S_RPH;
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				// rotation by three reversals: whole range, first k, the rest
				S_RPH: begin
					case (ph_q)
						2'd0: begin
							lo_q <= base_q;
							hi_q <= base_q + n_q - CW'(1);
						end
						2'd1: begin
							lo_q <= base_q;
							hi_q <= base_q + k_q - CW'(1);
						end
						default: begin
							lo_q <= base_q + k_q;
							hi_q <= base_q + n_q - CW'(1);
						end
					endcase
					state_q <= S_SWC;
				end
				S_SWC: begin
					if (lo_q < hi_q) begin
						state_q <= S_SWR1;
					end else if (ph_q == 2'd2) begin
						state_q <= S_FIN;
					end else begin
						ph_q    <= ph_q + 2'd1;
						state_q <= S_RPH;
					end
				end
				S_SWR1: state_q <= S_SWR2;
				S_SWR2: begin
					x_q     <= rdata;
					state_q <= S_SWW1;
				end
				S_SWW1: state_q <= S_SWW2;
				S_SWW2: begin
					lo_q    <= lo_q + CW'(1);
					hi_q    <= hi_q - CW'(1);
					state_q <= S_SWC;
				end
				S_FIN: begin
					mv_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
